FILE: src/sba_pkg.sv
// Shared types for the ascending block sorter.
package sba_pkg;

    localparam int unsigned DATA_W = 32;

    // One stored element: valid flag and signed value (empty sorts above any value)
    typedef struct packed {
        logic                     vld;
        logic signed [DATA_W-1:0] val;
    } sba_key_t;

    // Control broadcast to every cell
    typedef struct packed {
        logic                     insert;
        logic                     shift;
        logic signed [DATA_W-1:0] value;
    } sba_ctrl_t;

endpackage

FILE: src/sba_item_if.sv
// Input channel: one element of the set per transaction.
interface sba_item_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic               last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

FILE: src/sba_result_if.sv
// Output channel: one sorted element per transaction.
interface sba_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sorted_value;
    logic               final_res;
    logic               dropped;

    modport source (output valid, output sorted_value, output final_res, output dropped,
                    input ready);
    modport sink   (input valid, input sorted_value, input final_res, input dropped,
                    output ready);
endinterface

FILE: src/sort_block_ascending_core.sv
// Elements enter one per cycle while filling; the first result shows the cycle after the last
// element is accepted, then one sorted result per cycle while the sink is ready.
// A set of M elements (N kept) passes through the DEPTH-cell insertion chain, which fills
// and then drains by shifting toward cell 0.
// Reset clears every cell, the drain state and the discard flag; no clearing pass needed.
module sort_block_ascending_core
    import sba_pkg::*;
#(
    parameter int unsigned DEPTH = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    sba_item_if.sink     item,
    sba_result_if.source result
);

    typedef enum logic {ST_FILL, ST_DRAIN} state_t;

    state_t    state_reg;
    state_t    state_next;
    logic      overflow_reg;
    logic      overflow_next;
    sba_ctrl_t ctrl;
    sba_key_t  keys [DEPTH];
    logic      lts  [DEPTH];
    logic      item_fire;
    logic      result_fire;
    logic      full;

    assign full        = keys[DEPTH-1].vld;
    assign item.ready  = (state_reg == ST_FILL);
    assign item_fire   = item.valid && item.ready;
    assign result_fire = result.valid && result.ready;

    // Broadcast insert or drain shift to the chain
    assign ctrl.insert = item_fire && !full;
    assign ctrl.shift  = result_fire;
    assign ctrl.value  = item.value;

    // Cell chain, cell 0 holds the smallest element
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        sba_key_t pk;
        logic     plt;
        sba_key_t nk;

        if (i == 0)
        begin : g_head
            assign pk  = '0;
            assign plt = 1'b0;
        end
        else
        begin : g_body
            assign pk  = keys[i-1];
            assign plt = lts[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign nk = '0;
        end
        else
        begin : g_mid
            assign nk = keys[i+1];
        end

        sba_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .prev_key (pk),
            .prev_lt  (plt),
            .next_key (nk),
            .key      (keys[i]),
            .lt       (lts[i])
        );
    end

    // Output straight from the head cell
    assign result.valid        = (state_reg == ST_DRAIN);
    assign result.sorted_value = keys[0].val;
    assign result.final_res    = !keys[1].vld;
    assign result.dropped      = !keys[1].vld && overflow_reg;

    // Fill until the last element, drain until the final transaction
    always_comb
    begin
        state_next    = state_reg;
        overflow_next = overflow_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                if (item_fire)
                begin
                    if (full)
                    begin
                        overflow_next = 1'b1;
                    end
                    if (item.last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (result_fire && result.final_res)
                begin
                    state_next    = ST_FILL;
                    overflow_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_FILL;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            overflow_reg <= overflow_next;
        end
    end

    // The head cell always holds an element while draining
    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> keys[0].vld)
        else $error("drain with empty head cell");

    // Final transaction empties the chain
    a_final_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (result_fire && result.final_res) |=> (!keys[0].vld && !result.valid))
        else $error("chain not empty after final result");

    // Discard flag only ever reported on the final result
    a_drop_final: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.dropped) |-> result.final_res)
        else $error("dropped on non-final result");

    // A last element starts the drain in the next cycle
    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && item.last) |=> result.valid)
        else $error("no drain after last element");

endmodule

FILE: src/sba_cell.sv
// One cell of the systolic insertion sorter chain.
module sba_cell
    import sba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sba_ctrl_t ctrl,
    input  sba_key_t  prev_key,
    input  logic      prev_lt,
    input  sba_key_t  next_key,
    output sba_key_t  key,
    output logic      lt
);

    sba_key_t key_reg;
    sba_key_t key_next;

    // New value belongs at or before this cell
    assign lt  = !key_reg.vld || (ctrl.value < key_reg.val);
    assign key = key_reg;

    // Shift left while draining; on insert take the new value or the left neighbor
    always_comb
    begin
        key_next = key_reg;
        if (ctrl.shift)
        begin
            key_next = next_key;
        end
        else if (ctrl.insert && lt)
        begin
            if (prev_lt)
            begin
                key_next = prev_key;
            end
            else
            begin
                key_next.vld = 1'b1;
                key_next.val = ctrl.value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg.vld <= 1'b0;
            key_reg.val <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

endmodule
